// File: rtl/core/led_blink_slot_table_defines.svh
// Assertion macros for the LED blink slot table.
// Used by rtl/core/led_blink_slot_table.sv; expects clk_i and rst_ni in scope.
`ifndef LED_BLINK_SLOT_TABLE_DEFINES_SVH
`define LED_BLINK_SLOT_TABLE_DEFINES_SVH

`ifndef SYNTH
`define LBST_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define LBST_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LBST_ASSERT(name, prop, msg)
`define LBST_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

// File: rtl/core/lbst_pkg.sv
// Package of the LED blink slot table: sizes, command and action codes, result type.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package lbst_pkg;

  localparam int unsigned SLOTS      = 16;
  localparam int unsigned LED_COUNT  = 64;
  localparam int unsigned SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned MIN_PERIOD = 2;

  // Total of elapsed time and tick is 17 bits, so the divider runs 17 steps.
  localparam int unsigned DIV_STEPS  = 17;
  localparam int unsigned CNT_W      = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_BLINK    = 2'd1,
    CMD_STOP     = 2'd2,
    CMD_STOP_ALL = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_COMMIT = 2'd2
  } act_e;

  typedef struct packed {
    act_e        action;
    logic [7:0]  led;
    logic [23:0] colour;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/core/lbst_cmd_if.sv
// Command channel of the LED blink slot table: valid, ready and one command beat.
// Takes the command codes from lbst_pkg.
`default_nettype none

interface lbst_cmd_if import lbst_pkg::*; ();
  logic        valid;
  logic        ready;
  cmd_e        command;
  logic [7:0]  led;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [15:0] period;
  logic [15:0] tick_ms;

  modport source (
    output valid, command, led, red, green, blue, period, tick_ms,
    input  ready
  );
  modport sink (
    input  valid, command, led, red, green, blue, period, tick_ms,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/core/lbst_res_if.sv
// Result channel of the LED blink slot table: valid, ready and one layer action beat.
// Takes the action codes from lbst_pkg.
`default_nettype none

interface lbst_res_if import lbst_pkg::*; ();
  logic       valid;
  logic       ready;
  act_e       action;
  logic [7:0] led_index;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       last;

  modport source (
    output valid, action, led_index, out_red, out_green, out_blue, last,
    input  ready
  );
  modport sink (
    input  valid, action, led_index, out_red, out_green, out_blue, last,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/core/led_blink_slot_table.sv
// LED blink slot table: slot store, scan sequencer and shared restoring divider.
// Depends on lbst_pkg, lbst_cmd_if, lbst_res_if and led_blink_slot_table_defines.svh.
//
//   channel  modport  direction  beat
//   cmd_i    sink     in         command, led, red, green, blue, period, tick_ms
//   res_o    source   out        action, led_index, out_red, out_green, out_blue, last
//
// One command is taken at a time; cmd_i.ready is high only while the sequencer is idle.
// Stop all goes straight to the flush; blink and stop one LED each run one slot scan.
// A tick checks every slot and emits a write beat for each slot that comes out lit;
// each busy slot first runs the one-bit-per-cycle divider over DIV_STEPS steps.
// Results pass through a pending register and an output register, so a stalled res_o
// only holds the sequencer when it must place a new beat. Reset clears the table at once.
`default_nettype none
`include "led_blink_slot_table_defines.svh"

module led_blink_slot_table import lbst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  lbst_cmd_if.sink  cmd_i,
  lbst_res_if.source res_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_B_SCAN,
    ST_B_WRITE,
    ST_S_SCAN,
    ST_T_CHECK,
    ST_T_DIV,
    ST_T_UPD,
    ST_T_EMIT,
    ST_T_END,
    ST_FLUSH
  } state_e;

  state_e              state_q;
  logic [SLOT_W-1:0]   idx_q;
  logic [SLOTS-1:0]    active_q;
  logic [SLOTS-1:0]    lit_q;
  logic                changed_q;
  logic                match_found_q;
  logic [SLOT_W-1:0]   match_idx_q;
  logic                free_found_q;
  logic [SLOT_W-1:0]   free_idx_q;

  logic [7:0]          led_q;
  logic [23:0]         colour_q;
  logic [15:0]         period_q;
  logic [15:0]         ms_q;

  logic [16:0]         dvd_q;
  logic [14:0]         rem_q;
  logic [14:0]         half_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                qnz_q;
  logic                qlsb_q;

  logic                pend_valid_q;
  res_t                pend_q;
  logic                out_valid_q;
  res_t                out_q;
  logic                out_last_q;

  logic [7:0]          slot_led_q     [SLOTS];
  logic [23:0]         slot_colour_q  [SLOTS];
  logic [15:0]         slot_period_q  [SLOTS];
  logic [15:0]         slot_elapsed_q [SLOTS];

  logic                accept;
  logic                out_free;
  logic                place_beat;
  logic                last_idx;
  logic                led_hit;
  logic                new_lit;
  logic                blink_ok;
  logic [SLOT_W-1:0]   chosen;
  logic [16:0]         total;
  logic [15:0]         trial;
  logic                ge;
  logic [15:0]         rem_d;

  assign cmd_i.ready = (state_q == ST_IDLE);
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign out_free    = !out_valid_q || res_o.ready;
  // High in the cycles where the sequencer loads a new beat into the output register.
  assign place_beat  = out_free && ((state_q == ST_T_EMIT) || (state_q == ST_FLUSH) ||
                                    ((state_q == ST_T_END) && changed_q));
  assign last_idx    = (idx_q == SLOT_W'(SLOTS - 1));
  assign led_hit     = active_q[idx_q] && (slot_led_q[idx_q] == led_q);
  assign new_lit     = lit_q[idx_q] ^ qlsb_q;
  assign blink_ok    = (cmd_i.period >= 16'(MIN_PERIOD)) &&
                       ({1'b0, cmd_i.led} < 9'(LED_COUNT));
  assign chosen      = match_found_q ? match_idx_q :
                       (free_found_q ? free_idx_q : '0);
  assign total       = {1'b0, slot_elapsed_q[idx_q]} + {1'b0, ms_q};

  // One restoring division step: shift in the next dividend bit, subtract if it fits.
  assign trial = {rem_q, dvd_q[16]};
  assign ge    = (trial >= {1'b0, half_q});
  assign rem_d = ge ? (trial - {1'b0, half_q}) : trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      idx_q         <= '0;
      active_q      <= '0;
      lit_q         <= '0;
      changed_q     <= 1'b0;
      match_found_q <= 1'b0;
      match_idx_q   <= '0;
      free_found_q  <= 1'b0;
      free_idx_q    <= '0;
      cnt_q         <= '0;
      qnz_q         <= 1'b0;
      qlsb_q        <= 1'b0;
      pend_valid_q  <= 1'b0;
      out_valid_q   <= 1'b0;
      out_last_q    <= 1'b0;
    end else begin
      if (res_o.ready && !place_beat) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            led_q         <= cmd_i.led;
            colour_q      <= {cmd_i.red, cmd_i.green, cmd_i.blue};
            period_q      <= cmd_i.period;
            ms_q          <= cmd_i.tick_ms;
            idx_q         <= '0;
            match_found_q <= 1'b0;
            free_found_q  <= 1'b0;
            changed_q     <= 1'b0;
            case (cmd_i.command)
              CMD_TICK: begin
                pend_q       <= '{action: ACT_CLEAR, led: '0, colour: '0};
                pend_valid_q <= 1'b1;
                state_q      <= ST_T_CHECK;
              end
              CMD_BLINK: begin
                if (blink_ok) begin
                  state_q <= ST_B_SCAN;
                end
              end
              CMD_STOP: begin
                state_q <= ST_S_SCAN;
              end
              default: begin
                active_q     <= '0;
                lit_q        <= '0;
                pend_q       <= '{action: ACT_CLEAR, led: '0, colour: '0};
                pend_valid_q <= 1'b1;
                state_q      <= ST_FLUSH;
              end
            endcase
          end
        end
        ST_B_SCAN: begin
          if (!match_found_q && led_hit) begin
            match_found_q <= 1'b1;
            match_idx_q   <= idx_q;
          end
          if (!free_found_q && !active_q[idx_q]) begin
            free_found_q <= 1'b1;
            free_idx_q   <= idx_q;
          end
          if (last_idx) begin
            state_q <= ST_B_WRITE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_B_WRITE: begin
          active_q[chosen] <= 1'b1;
          lit_q[chosen]    <= 1'b1;
          state_q          <= ST_IDLE;
        end
        ST_S_SCAN: begin
          if (led_hit) begin
            active_q[idx_q] <= 1'b0;
            lit_q[idx_q]    <= 1'b0;
          end
          if (last_idx) begin
            pend_q       <= '{action: ACT_WRITE, led: led_q, colour: '0};
            pend_valid_q <= 1'b1;
            state_q      <= ST_FLUSH;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_T_CHECK: begin
          if (active_q[idx_q]) begin
            dvd_q   <= total;
            rem_q   <= '0;
            half_q  <= slot_period_q[idx_q][15:1];
            cnt_q   <= CNT_W'(DIV_STEPS - 1);
            qnz_q   <= 1'b0;
            qlsb_q  <= 1'b0;
            state_q <= ST_T_DIV;
          end else if (last_idx) begin
            state_q <= ST_T_END;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_T_DIV: begin
          rem_q  <= rem_d[14:0];
          dvd_q  <= {dvd_q[15:0], 1'b0};
          qnz_q  <= qnz_q | ge;
          qlsb_q <= ge;
          if (cnt_q == '0) begin
            state_q <= ST_T_UPD;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        ST_T_UPD: begin
          lit_q[idx_q] <= new_lit;
          if (qnz_q) begin
            changed_q <= 1'b1;
          end
          if (new_lit) begin
            state_q <= ST_T_EMIT;
          end else if (last_idx) begin
            state_q <= ST_T_END;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= ST_T_CHECK;
          end
        end
        ST_T_EMIT: begin
          if (out_free) begin
            out_q       <= pend_q;
            out_last_q  <= 1'b0;
            out_valid_q <= 1'b1;
            pend_q      <= '{action: ACT_WRITE, led: slot_led_q[idx_q],
                             colour: slot_colour_q[idx_q]};
            if (last_idx) begin
              state_q <= ST_T_END;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= ST_T_CHECK;
            end
          end
        end
        ST_T_END: begin
          if (!changed_q) begin
            state_q <= ST_FLUSH;
          end else if (out_free) begin
            out_q       <= pend_q;
            out_last_q  <= 1'b0;
            out_valid_q <= 1'b1;
            pend_q      <= '{action: ACT_COMMIT, led: '0, colour: '0};
            state_q     <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          // The held beat is the final one of this command.
          if (out_free) begin
            out_q        <= pend_q;
            out_last_q   <= 1'b1;
            out_valid_q  <= 1'b1;
            pend_valid_q <= 1'b0;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Slot payload; it is only read for active slots, which a blink has written.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_B_WRITE) begin
      slot_led_q[chosen]     <= led_q;
      slot_colour_q[chosen]  <= colour_q;
      slot_period_q[chosen]  <= period_q;
      slot_elapsed_q[chosen] <= '0;
    end
    if (state_q == ST_T_UPD) begin
      slot_elapsed_q[idx_q] <= {1'b0, rem_q};
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.action    = out_q.action;
  assign res_o.led_index = out_q.led;
  assign res_o.out_red   = out_q.colour[23:16];
  assign res_o.out_green = out_q.colour[15:8];
  assign res_o.out_blue  = out_q.colour[7:0];
  assign res_o.last      = out_last_q;

  `LBST_ASSERT(a_lit_needs_active, (lit_q & ~active_q) == '0, "lit slot is not active")
  `LBST_ASSERT(a_rem_below_half, (state_q == ST_T_DIV) |-> (rem_q < half_q), "remainder not below half period")
  `LBST_ASSERT(a_pend_held, (state_q == ST_T_CHECK || state_q == ST_T_DIV || state_q == ST_T_UPD || state_q == ST_T_EMIT || state_q == ST_T_END || state_q == ST_FLUSH) |-> pend_valid_q, "no pending beat during result sequence")
  `LBST_ASSERT_NEXT(a_stop_all_clears, accept && cmd_i.command == CMD_STOP_ALL, active_q == '0, "stop all left a slot active")
  `LBST_ASSERT_NEXT(a_flush_ends, state_q == ST_FLUSH && out_free, state_q == ST_IDLE && out_valid_q && out_last_q, "final beat not placed with last")

endmodule

`default_nettype wire
